// File: rtl/pdic_pkg.sv
// Package for the pattern dictionary index codec.
// Holds sizes, operation and status codes, register indexes and the shared types.
// No dependencies.
`timescale 1ns / 1ps

package pdic_pkg;

  localparam int DICT_DEPTH   = 256;
  localparam int PATTERN_BITS = 64;
  localparam int IDX_W        = $clog2(DICT_DEPTH);
  localparam int ENTRY_IDX_W  = 8;
  localparam int COUNT_W      = 9;
  localparam int CMP_W        = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int FIELD_W      = 64;

  localparam logic [COUNT_W-1:0] NARROW_MAX_COUNT = COUNT_W'(255);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_MATCH     = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE    = 2'd2;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

  localparam int PADDR_W = 3;
  localparam logic REG_PATTERN_COUNT = 1'b0;
  localparam logic REG_NARROW_MODE   = 1'b1;

  typedef struct packed {
    logic [1:0]             op;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [FIELD_W-1:0]     block_bits;
  } pdic_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [ENTRY_IDX_W-1:0] match_index;
    logic [FIELD_W-1:0]     pattern_bits;
  } pdic_rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pattern_count;
    logic               narrow_index_mode;
  } pdic_cfg_t;

  // idx carries the entry index in, and the match index out on encode;
  // bits carries the block in, and the stored pattern out on decode.
  typedef struct packed {
    logic                    valid;
    logic [1:0]              op;
    logic [ENTRY_IDX_W-1:0]  idx;
    logic [PATTERN_BITS-1:0] bits;
    logic                    hit;
  } pdic_token_t;

endpackage

// File: rtl/pdic_cfg.sv
// Configuration registers behind an APB-style port.
// Depends on pdic_pkg.
`timescale 1ns / 1ps

module pdic_cfg import pdic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pdic_cfg_t          cfg
);

  logic reg_sel;
  logic wr_en;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_COUNT: cfg.pattern_count     <= pwdata[COUNT_W-1:0];
        REG_NARROW_MODE:   cfg.narrow_index_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_COUNT: prdata = 32'(cfg.pattern_count);
      REG_NARROW_MODE:   prdata = 32'(cfg.narrow_index_mode);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: rtl/pdic_cell.sv
// One dictionary cell: holds one stored pattern and one request stage.
// Depends on pdic_pkg.
`timescale 1ns / 1ps

module pdic_cell import pdic_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [IDX_W-1:0] cell_index,
  input  pdic_cfg_t        cfg,
  input  pdic_token_t      tok_in,
  output pdic_token_t      tok_out
);

  logic [PATTERN_BITS-1:0] entry;
  pdic_token_t             tok_next;
  logic                    idx_hit;
  logic                    in_range;

  assign idx_hit  = CMP_W'(cell_index) == CMP_W'(tok_in.idx);
  assign in_range = CMP_W'(cell_index) < CMP_W'(cfg.pattern_count);

  always_comb begin
    tok_next = tok_in;
    case (tok_in.op)
      OP_ENCODE: begin
        if (!tok_in.hit && in_range && entry == tok_in.bits) begin
          tok_next.hit = 1'b1;
          tok_next.idx = ENTRY_IDX_W'(cell_index);
        end
      end
      OP_DECODE: begin
        if (idx_hit && in_range) begin
          tok_next.hit  = 1'b1;
          tok_next.bits = entry;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in.valid && tok_in.op == OP_LOAD && idx_hit) begin
      entry <= tok_in.bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

  a_hit_sticks: assert property (@(posedge clk) disable iff (rst)
    advance && tok_in.valid && tok_in.hit |=> tok_out.hit)
    else $error("hit flag dropped in cell");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance && !$past(rst) |=> $stable(tok_out))
    else $error("cell stage moved while stalled");

endmodule

// File: rtl/pdic_chain.sv
// Row of dictionary cells; requests step one cell per advancing cycle.
// Depends on pdic_pkg and pdic_cell.
`timescale 1ns / 1ps

module pdic_chain import pdic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  pdic_cfg_t   cfg,
  input  pdic_token_t head,
  output pdic_token_t tail
);

  pdic_token_t link [0:DICT_DEPTH];

  assign link[0] = head;
  assign tail    = link[DICT_DEPTH];

  for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
    pdic_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (IDX_W'(i)),
      .cfg        (cfg),
      .tok_in     (link[i]),
      .tok_out    (link[i+1])
    );
  end

endmodule

// File: rtl/pattern_dictionary_index_codec_top.sv
// Top level of the pattern dictionary index codec.
// Depends on pdic_pkg, pdic_cfg, pdic_chain and pdic_cell.
//
//   channel  ports                           direction  accepted when
//   req      req_valid, req_stall, req       in         req_valid && !req_stall
//   rsp      rsp_valid, rsp_stall, rsp       out        rsp_valid && !rsp_stall
//   apb      psel, penable, pwrite, paddr,   in/out     psel && penable && pwrite
//            pwdata, prdata, pready
//
// One request enters per cycle while req_stall is low; its result passes through
// the register of each dictionary cell, then the output register.
// The cell row is a single pipeline: a stalled rsp freezes every stage at once.
// Reset clears the stage valid bits, rsp_valid and the configuration registers;
// stored patterns are undefined until loaded, and no clearing pass runs.
`timescale 1ns / 1ps

module pattern_dictionary_index_codec_top import pdic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  pdic_req_t          req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pdic_rsp_t          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  pdic_cfg_t   cfg;
  pdic_token_t head;
  pdic_token_t tail;
  pdic_rsp_t   rsp_next;
  logic        advance;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = !advance;

  pdic_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    head.valid = req_valid;
    head.op    = req.op;
    head.idx   = req.entry_index;
    head.bits  = req.block_bits[PATTERN_BITS-1:0];
    head.hit   = 1'b0;
  end

  pdic_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .head    (head),
    .tail    (tail)
  );

  always_comb begin
    rsp_next = '0;
    case (tail.op)
      OP_ENCODE: begin
        if (cfg.narrow_index_mode && cfg.pattern_count > NARROW_MAX_COUNT) begin
          rsp_next.status = ST_TOO_LARGE;
        end else if (tail.hit) begin
          rsp_next.match_index = tail.idx;
        end else begin
          rsp_next.status = ST_NO_MATCH;
        end
      end
      OP_DECODE: begin
        if (tail.hit) begin
          rsp_next.pattern_bits = FIELD_W'(tail.bits);
        end else begin
          rsp_next.status = ST_OUT_OF_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.match_index == '0 && rsp.pattern_bits == '0)
    else $error("failed result carries data");

  a_too_large_cause: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_TOO_LARGE |->
      cfg.narrow_index_mode && cfg.pattern_count > NARROW_MAX_COUNT)
    else $error("count-too-large status without cause");

endmodule
